/* design/pab_pkg.sv */
// pab_pkg: shared constants, types and helpers of the pixel alpha blender
// no dependencies
`default_nettype none

package pab_pkg;

  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CH_W-1:0] FULL_WEIGHT = 8'd255;

  typedef enum logic [2:0] {
    MODE_MASK = 3'd0,
    MODE_RGB  = 3'd1,
    MODE_RGBA = 3'd2,
    MODE_PAL  = 3'd3,
    MODE_FILL = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND_MODE    = 3'd0,
    CFG_GLOBAL_ALPHA  = 3'd1,
    CFG_FILL_RED      = 3'd2,
    CFG_FILL_GREEN    = 3'd3,
    CFG_FILL_BLUE     = 3'd4,
    CFG_PAL_ALPHA_CNT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t            color;
    logic [CH_W-1:0] alpha;
  } pal_entry_t;

  typedef struct packed {
    rgb_t            src;
    rgb_t            dst;
    logic [CH_W-1:0] weight;
  } blend_item_t;

  // exact floor(x/255) for x up to 255*255
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] t;
    t = {1'b0, x} + (2*CH_W+1)'(x[2*CH_W-1:CH_W]) + (2*CH_W+1)'(1);
    return t[2*CH_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

/* design/pab_ifs.sv */
// pab_ifs: pixel input, result output and register write channels
// depends on pab_pkg
`default_nettype none

interface pab_pix_if
  import pab_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            func;
  logic [CH_W-1:0] src_index;
  logic [CH_W-1:0] src_red;
  logic [CH_W-1:0] src_green;
  logic [CH_W-1:0] src_blue;
  logic [CH_W-1:0] src_alpha;
  logic [CH_W-1:0] dst_red;
  logic [CH_W-1:0] dst_green;
  logic [CH_W-1:0] dst_blue;

  modport source (
    output valid, func, src_index, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue,
    input  ready
  );
  modport sink (
    input  valid, func, src_index, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue,
    output ready
  );
endinterface

interface pab_res_if
  import pab_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface pab_cfg_if
  import pab_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/pab_front.sv */
// pab_front: accepts beats, holds the registers and the palette, derives the weight
// depends on pab_pkg and pab_ifs
`default_nettype none

module pab_front
  import pab_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pab_pix_if.sink     pix_i,
  pab_cfg_if.sink     cfg_i,
  output blend_item_t push_item_o,
  output logic        push_valid_o,
  input  wire logic   push_ready_i
);

  logic [2:0]            blend_mode_q;
  logic [CH_W-1:0]       global_alpha_q;
  rgb_t                  fill_q;
  logic [CFG_DATA_W-1:0] pal_alpha_cnt_q;

  pal_entry_t palette_mem [PAL_ENTRIES];
  pal_entry_t pal_rd_q;

  logic            s1_valid_q, s2_valid_q;
  logic            s1_ready, s2_ready;
  logic            accept, in_range;
  rgb_t            s1_src_q, s1_dst_q;
  logic [CH_W-1:0] s1_sa_q;
  logic            s1_use_pal_alpha_q, s1_in_range_q;

  rgb_t              s2_src_d, s2_src_q, s2_dst_q;
  logic [CH_W-1:0]   s2_raw_d, s2_direct_d, s2_direct_q;
  logic              s2_scale_d, s2_scale_q;
  logic [2*CH_W-1:0] s2_prod_q;
  logic [CH_W-1:0]   weight;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q    <= MODE_RGB;
      global_alpha_q  <= FULL_WEIGHT;
      fill_q          <= '0;
      pal_alpha_cnt_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_BLEND_MODE:    blend_mode_q    <= cfg_i.data[2:0];
        CFG_GLOBAL_ALPHA:  global_alpha_q  <= cfg_i.data[CH_W-1:0];
        CFG_FILL_RED:      fill_q.r        <= cfg_i.data[CH_W-1:0];
        CFG_FILL_GREEN:    fill_q.g        <= cfg_i.data[CH_W-1:0];
        CFG_FILL_BLUE:     fill_q.b        <= cfg_i.data[CH_W-1:0];
        CFG_PAL_ALPHA_CNT: pal_alpha_cnt_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign s2_ready    = !s2_valid_q || push_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign pix_i.ready = s1_ready;
  assign accept      = pix_i.valid && s1_ready;
  assign in_range    = {1'b0, pix_i.src_index} < (CH_W+1)'(PAL_ENTRIES);

  // palette port: write on an entry beat, registered read on a pixel beat
  always_ff @(posedge clk_i) begin
    if (accept && pix_i.func && in_range) begin
      palette_mem[pix_i.src_index[PAL_AW-1:0]] <= '{
        color: '{r: pix_i.src_red, g: pix_i.src_green, b: pix_i.src_blue},
        alpha: pix_i.src_alpha};
    end
    if (s1_ready) begin
      pal_rd_q <= palette_mem[pix_i.src_index[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= accept && !pix_i.func;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_src_q           <= '{r: pix_i.src_red, g: pix_i.src_green, b: pix_i.src_blue};
      s1_dst_q           <= '{r: pix_i.dst_red, g: pix_i.dst_green, b: pix_i.dst_blue};
      s1_sa_q            <= pix_i.src_alpha;
      s1_in_range_q      <= in_range;
      s1_use_pal_alpha_q <= {1'b0, pix_i.src_index} < pal_alpha_cnt_q;
    end
  end

  always_comb begin
    s2_src_d    = s1_src_q;
    s2_raw_d    = s1_sa_q;
    s2_direct_d = global_alpha_q;
    s2_scale_d  = 1'b0;
    case (mode_e'(blend_mode_q))
      MODE_MASK: begin
        s2_src_d    = fill_q;
        s2_direct_d = s1_sa_q;
      end
      MODE_RGB: ;
      MODE_RGBA: begin
        s2_scale_d = 1'b1;
      end
      MODE_PAL: begin
        s2_src_d   = s1_in_range_q ? pal_rd_q.color : '0;
        s2_raw_d   = s1_in_range_q ? pal_rd_q.alpha : '0;
        s2_scale_d = s1_use_pal_alpha_q;
      end
      MODE_FILL: begin
        s2_src_d = fill_q;
      end
      default: begin
        s2_direct_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_src_q    <= s2_src_d;
      s2_dst_q    <= s1_dst_q;
      s2_direct_q <= s2_direct_d;
      s2_scale_q  <= s2_scale_d;
      s2_prod_q   <= {{CH_W{1'b0}}, s2_raw_d} * {{CH_W{1'b0}}, global_alpha_q};
    end
  end

  assign weight = (global_alpha_q == '0) ? '0 :
                  s2_scale_q             ? div255(s2_prod_q) : s2_direct_q;

  assign push_valid_o = s2_valid_q;
  assign push_item_o  = '{src: s2_src_q, dst: s2_dst_q, weight: weight};

endmodule

`default_nettype wire

/* design/pab_queue.sv */
// pab_queue: short queue of blend items between the front and the back
// depends on pab_pkg
`default_nettype none

module pab_queue
  import pab_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire blend_item_t push_item_i,
  input  wire logic        push_valid_i,
  output logic             push_ready_o,
  output blend_item_t      pop_item_o,
  output logic             pop_valid_o,
  input  wire logic        pop_ready_i
);

  blend_item_t         entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0] count_q;
  logic                push, pop;

  assign push_ready_o = count_q != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not shrink on pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == QUEUE_CW'(QUEUE_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

/* design/pab_back.sv */
// pab_back: per-channel source-over mix and the result register
// depends on pab_pkg and pab_ifs
`default_nettype none

module pab_back
  import pab_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire blend_item_t pop_item_i,
  input  wire logic        pop_valid_i,
  output logic             pop_ready_o,
  pab_res_if.source        res_o
);

  logic              b1_valid_q, b2_valid_q;
  logic              b1_ready, b2_ready;
  logic [CH_W-1:0]   inv_w;
  logic [2*CH_W-1:0] sp_r_q, sp_g_q, sp_b_q;
  logic [2*CH_W-1:0] dp_r_q, dp_g_q, dp_b_q;
  rgb_t              res_q;

  assign b2_ready    = !b2_valid_q || res_o.ready;
  assign b1_ready    = !b1_valid_q || b2_ready;
  assign pop_ready_o = b1_ready;
  assign inv_w       = FULL_WEIGHT - pop_item_i.weight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid_q <= pop_valid_i;
      end
      if (b2_ready) begin
        b2_valid_q <= b1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_ready) begin
      sp_r_q <= {{CH_W{1'b0}}, pop_item_i.src.r} * {{CH_W{1'b0}}, pop_item_i.weight};
      sp_g_q <= {{CH_W{1'b0}}, pop_item_i.src.g} * {{CH_W{1'b0}}, pop_item_i.weight};
      sp_b_q <= {{CH_W{1'b0}}, pop_item_i.src.b} * {{CH_W{1'b0}}, pop_item_i.weight};
      dp_r_q <= {{CH_W{1'b0}}, pop_item_i.dst.r} * {{CH_W{1'b0}}, inv_w};
      dp_g_q <= {{CH_W{1'b0}}, pop_item_i.dst.g} * {{CH_W{1'b0}}, inv_w};
      dp_b_q <= {{CH_W{1'b0}}, pop_item_i.dst.b} * {{CH_W{1'b0}}, inv_w};
    end
    if (b2_ready) begin
      res_q.r <= div255(sp_r_q + dp_r_q);
      res_q.g <= div255(sp_g_q + dp_g_q);
      res_q.b <= div255(sp_b_q + dp_b_q);
    end
  end

  assign res_o.valid     = b2_valid_q;
  assign res_o.out_red   = res_q.r;
  assign res_o.out_green = res_q.g;
  assign res_o.out_blue  = res_q.b;

endmodule

`default_nettype wire

/* design/pixel_alpha_blender.sv */
// Pixel alpha blender: blends one source pixel over one destination RGB pixel
// per beat, weights chosen by the blend mode register. One pixel or palette
// entry beat is taken every clock unless a full queue holds the front. A
// pixel beat is registered in turn by the palette read register, the weight
// multiply stage, the queue entry and two back stages (channel multiplies,
// divide by 255 into the result register). A four-entry queue lets the front
// keep taking beats while the result side stalls, until it fills. A palette
// entry beat writes the table and yields no result. Registers must be written
// only while the block is idle; the block itself does not enforce this.
// depends on pab_pkg, pab_ifs, pab_front, pab_queue, pab_back
`default_nettype none

module pixel_alpha_blender
  import pab_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pab_pix_if.sink   pix_i,
  pab_cfg_if.sink   cfg_i,
  pab_res_if.source res_o
);

  blend_item_t push_item, pop_item;
  logic        push_valid, push_ready, pop_valid, pop_ready;

  pab_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .cfg_i        (cfg_i),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  pab_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  pab_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_item_i  (pop_item),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
